// ----- sv/rwg_pkg.sv -----
package rwg_pkg;

    localparam int EXP_TABLE_DEPTH = 256;
    localparam int EXP_STAGES = 11;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W = 32 + TAB_AW;
    localparam int DIFF_W = 31 - IDX_W;
    localparam int PROD_W = DIFF_W + 32;
    localparam int QUOT_SH = 62 - DIFF_W;
    localparam int IDX_SH = 63 - IDX_W;

    // Reciprocals used to replace the divisions by ln2 with multiplications.
    localparam logic [63:0] RECIP_FULL = (64'd1 << 62) / 64'(LN2_Q32);
    localparam logic [31:0] RECIP_Q62 = RECIP_FULL[31:0];
    localparam logic [63:0] IDX_RECIP_FULL =
        (64'(EXP_TABLE_DEPTH) << IDX_SH) / 64'(LN2_Q32);
    localparam logic [31:0] IDX_RECIP = IDX_RECIP_FULL[31:0];

    typedef enum logic [2:0] {
        CFG_START_TIME = 3'd0,
        CFG_CENTER_TIME = 3'd1,
        CFG_INV_PERIOD_SCALE = 3'd2,
        CFG_AMPLITUDE_GAIN = 3'd3,
        CFG_NEGATE_MODE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [30:0] pm_hi;
    } rwg_tag_t;

    typedef logic [30:0] exp_tab_t [EXP_TABLE_DEPTH + 1];

    // Samples of exp(-x) over [0, ln2] from a Q30 Taylor series.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t           tab;
        logic [63:0]        x32;
        logic [63:0]        x30;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
        begin
            x32 = (64'(i) * 64'(LN2_Q32)) / EXP_TABLE_DEPTH;
            x30 = (x32 + 64'd2) >> 2;
            sum = signed'(64'(ONE_Q30));
            term = 64'(ONE_Q30);
            for (int n = 1; n <= 20; n++)
            begin
                term = ((term * x30) >> 30) / 64'(n);
                if ((n % 2) == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            tab[i] = (sum < 0) ? 31'd0 : sum[30:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ----- sv/rwg_exp.sv -----
module rwg_exp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [37:0]        t1,
    input  rwg_pkg::rwg_tag_t  tag_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        e_out,
    output rwg_pkg::rwg_tag_t  tag_out
);

    localparam int N = rwg_pkg::EXP_STAGES;
    localparam int IW = rwg_pkg::IDX_W;
    localparam int AW = rwg_pkg::TAB_AW;
    localparam int PW = rwg_pkg::POS_W;
    localparam int DW = rwg_pkg::DIFF_W;
    localparam int QW = rwg_pkg::PROD_W;

    logic [N-1:0]      v_reg;
    logic [N-1:0]      en;
    rwg_pkg::rwg_tag_t tag_reg [N];

    logic [63:0]   e1_kp;
    logic [5:0]    e1_k_next, e1_k_reg;
    logic [37:0]   e1_t1_reg;
    logic [37:0]   e2_kl, e2_diff;
    logic [32:0]   e2_r0_next, e2_r0_reg;
    logic [5:0]    e2_k_reg;
    logic          e3_ge;
    logic [31:0]   e3_r_next, e3_r_reg;
    logic [5:0]    e3_k_next, e3_k_reg;
    logic [63:0]   e4_ip;
    logic [IW-1:0] e4_idx_next, e4_idx_reg;
    logic [31:0]   e4_r_reg;
    logic [5:0]    e4_k_reg;
    logic [PW-1:0] e5_pos, e5_idxl, e5_diff;
    logic [32:0]   e5_fr_next, e5_fr_reg;
    logic [IW-1:0] e5_idx_reg;
    logic [5:0]    e5_k_reg;
    logic          e6_ge;
    logic [IW:0]   e6_inc;
    logic [IW-1:0] e6_idx_next, e6_idx_reg;
    logic [31:0]   e6_frac_next, e6_frac_reg;
    logic [5:0]    e6_k_reg;
    logic [30:0]   e7_a_next, e7_a_reg, e7_b, e7_dfull;
    logic [DW-1:0] e7_diff_next, e7_diff_reg;
    logic [31:0]   e7_frac_reg;
    logic [5:0]    e7_k_reg;
    logic [QW-1:0] e8_prod_next, e8_prod_reg;
    logic [30:0]   e8_a_reg;
    logic [5:0]    e8_k_reg;
    logic [63:0]   e9_qp;
    logic [DW-1:0] e9_qe_next, e9_qe_reg;
    logic [QW-1:0] e9_prod_reg;
    logic [30:0]   e9_a_reg;
    logic [5:0]    e9_k_reg;
    logic [QW-1:0] e10_ql, e10_diff;
    logic [32:0]   e10_rem_next, e10_rem_reg;
    logic [DW-1:0] e10_qe_reg;
    logic [30:0]   e10_a_reg;
    logic [5:0]    e10_k_reg;
    logic [30:0]   e11_q, e11_v;
    logic [30:0]   e11_e_next, e11_e_reg;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[N-1];
    assign e_out = e11_e_reg;
    assign tag_out = tag_reg[N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0] <= tag_in;
        end
        for (int i = 1; i < N; i++)
        begin
            if (en[i])
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Range reduction: t1 = k * ln2 + r.
    always_comb
    begin
        e1_kp = 64'(t1[37:6]) * 64'(rwg_pkg::RECIP_Q62);
        e1_k_next = e1_kp[61:56];
        e2_kl = 38'(e1_k_reg) * 38'(rwg_pkg::LN2_Q32);
        e2_diff = e1_t1_reg - e2_kl;
        e2_r0_next = e2_diff[32:0];
        e3_ge = e2_r0_reg >= 33'(rwg_pkg::LN2_Q32);
        e3_r_next = e3_ge ? 32'(e2_r0_reg - 33'(rwg_pkg::LN2_Q32)) : e2_r0_reg[31:0];
        e3_k_next = e2_k_reg + 6'(e3_ge);
    end

    // Table position: idx and frac from r * depth / ln2.
    always_comb
    begin
        e4_ip = 64'(e3_r_reg) * 64'(rwg_pkg::IDX_RECIP);
        e4_idx_next = e4_ip[rwg_pkg::IDX_SH+IW-1:rwg_pkg::IDX_SH];
        e5_pos = PW'(e4_r_reg) * PW'(rwg_pkg::EXP_TABLE_DEPTH);
        e5_idxl = PW'(e4_idx_reg) * PW'(rwg_pkg::LN2_Q32);
        e5_diff = e5_pos - e5_idxl;
        e5_fr_next = e5_diff[32:0];
        e6_ge = e5_fr_reg >= 33'(rwg_pkg::LN2_Q32);
        e6_inc = (IW+1)'(e5_idx_reg) + (IW+1)'(e6_ge);
        if (e6_inc >= (IW+1)'(rwg_pkg::EXP_TABLE_DEPTH))
        begin
            e6_idx_next = IW'(rwg_pkg::EXP_TABLE_DEPTH - 1);
        end
        else
        begin
            e6_idx_next = e6_inc[IW-1:0];
        end
        e6_frac_next = e6_ge ? 32'(e5_fr_reg - 33'(rwg_pkg::LN2_Q32)) : e5_fr_reg[31:0];
    end

    // Interpolate between two table points, shift by k.
    always_comb
    begin
        e7_a_next = rwg_pkg::EXP_TAB[AW'(e6_idx_reg)];
        e7_b = rwg_pkg::EXP_TAB[AW'(e6_idx_reg) + AW'(1)];
        e7_dfull = e7_a_next - e7_b;
        e7_diff_next = e7_dfull[DW-1:0];
        e8_prod_next = QW'(e7_diff_reg) * QW'(e7_frac_reg);
        e9_qp = 64'(e8_prod_reg[QW-1:DW]) * 64'(rwg_pkg::RECIP_Q62);
        e9_qe_next = e9_qp[rwg_pkg::QUOT_SH+DW-1:rwg_pkg::QUOT_SH];
        e10_ql = QW'(e9_qe_reg) * QW'(rwg_pkg::LN2_Q32);
        e10_diff = e9_prod_reg - e10_ql;
        e10_rem_next = e10_diff[32:0];
        e11_q = 31'(e10_qe_reg) + 31'(e10_rem_reg >= 33'(rwg_pkg::LN2_Q32));
        e11_v = (e10_a_reg >= e11_q) ? (e10_a_reg - e11_q) : 31'd0;
        e11_e_next = e11_v >> e10_k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_t1_reg <= t1;
            e1_k_reg <= e1_k_next;
        end
        if (en[1])
        begin
            e2_r0_reg <= e2_r0_next;
            e2_k_reg <= e1_k_reg;
        end
        if (en[2])
        begin
            e3_r_reg <= e3_r_next;
            e3_k_reg <= e3_k_next;
        end
        if (en[3])
        begin
            e4_idx_reg <= e4_idx_next;
            e4_r_reg <= e3_r_reg;
            e4_k_reg <= e3_k_reg;
        end
        if (en[4])
        begin
            e5_fr_reg <= e5_fr_next;
            e5_idx_reg <= e4_idx_reg;
            e5_k_reg <= e4_k_reg;
        end
        if (en[5])
        begin
            e6_idx_reg <= e6_idx_next;
            e6_frac_reg <= e6_frac_next;
            e6_k_reg <= e5_k_reg;
        end
        if (en[6])
        begin
            e7_a_reg <= e7_a_next;
            e7_diff_reg <= e7_diff_next;
            e7_frac_reg <= e6_frac_reg;
            e7_k_reg <= e6_k_reg;
        end
        if (en[7])
        begin
            e8_prod_reg <= e8_prod_next;
            e8_a_reg <= e7_a_reg;
            e8_k_reg <= e7_k_reg;
        end
        if (en[8])
        begin
            e9_qe_reg <= e9_qe_next;
            e9_prod_reg <= e8_prod_reg;
            e9_a_reg <= e8_a_reg;
            e9_k_reg <= e8_k_reg;
        end
        if (en[9])
        begin
            e10_rem_reg <= e10_rem_next;
            e10_qe_reg <= e9_qe_reg;
            e10_a_reg <= e9_a_reg;
            e10_k_reg <= e9_k_reg;
        end
        if (en[10])
        begin
            e11_e_reg <= e11_e_next;
        end
    end

    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] && !tag_reg[2].zero |-> e3_r_reg < rwg_pkg::LN2_Q32)
        else $error("range reduction left a remainder of ln2 or more");

    a_frac_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && !tag_reg[5].zero |-> e6_frac_reg < rwg_pkg::LN2_Q32)
        else $error("table fraction is not below ln2");

    a_quot_close: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[9] && !tag_reg[9].zero |-> e10_rem_reg < {rwg_pkg::LN2_Q32, 1'b0})
        else $error("interpolation quotient estimate is off by more than one");

endmodule

// ----- sv/ricker_wavelet_generator.sv -----
// Throughput: one sample per cycle while m_tready does not stall the output;
// the 3 front stages, the 11 exp stages and the 3 back stages each hold one item,
// and a bubble in any stage can take a new one.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads
// the configuration registers with their defaults. The exp table is constant.
module ricker_wavelet_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] amplitude
    output logic        m_tuser    // [0] saturated
);

    logic [31:0] start_time_reg;
    logic [31:0] center_time_reg;
    logic [31:0] scale_reg;
    logic [31:0] gain_reg;
    logic        negate_reg;

    logic [2:0] vf_reg, en_f;
    logic [2:0] vb_reg, en_b;

    logic        f1_zero_next, f1_zero_reg;
    logic [32:0] f1_d;
    logic [31:0] f1_absd_next, f1_absd_reg;
    logic [63:0] f2_p;
    logic        f2_zero_next, f2_zero_reg;
    logic [26:0] f2_u24_next, f2_u24_reg;
    logic [54:0] f3_sq;
    logic [37:0] f3_t1_next, f3_t1_reg;
    logic        f3_zero_reg;

    logic [38:0]       two_t1, pm;
    rwg_pkg::rwg_tag_t tag_in, tag_out;
    logic              exp_in_ready, exp_out_valid;
    logic [30:0]       exp_e;

    logic [61:0] b1_wp;
    logic [30:0] b1_w_next, b1_w_reg;
    logic        b1_zero_reg, b1_neg_reg;
    logic [63:0] b2_mp;
    logic [33:0] b2_mag_next, b2_mag_reg;
    logic        b2_zero_reg, b2_neg_reg;
    logic        b3_neg;
    logic [31:0] out_amp_next, out_amp_reg;
    logic        out_sat_next, out_sat_reg;

    localparam logic [38:0] TWO_POW32 = 39'h1_0000_0000;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= 32'd0;
            center_time_reg <= 32'd983040;
            scale_reg <= 32'd337325979;
            gain_reg <= 32'd13107200;
            negate_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rwg_pkg::CFG_START_TIME:       start_time_reg <= cfg_data;
                rwg_pkg::CFG_CENTER_TIME:      center_time_reg <= cfg_data;
                rwg_pkg::CFG_INV_PERIOD_SCALE: scale_reg <= cfg_data;
                rwg_pkg::CFG_AMPLITUDE_GAIN:   gain_reg <= cfg_data;
                rwg_pkg::CFG_NEGATE_MODE:      negate_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    always_comb
    begin
        en_b[2] = !vb_reg[2] || m_tready;
        en_b[1] = !vb_reg[1] || en_b[2];
        en_b[0] = !vb_reg[0] || en_b[1];
        en_f[2] = !vf_reg[2] || exp_in_ready;
        en_f[1] = !vf_reg[1] || en_f[2];
        en_f[0] = !vf_reg[0] || en_f[1];
    end

    assign s_tready = en_f[0];
    assign m_tvalid = vb_reg[2];
    assign m_tdata = out_amp_reg;
    assign m_tuser = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
            vb_reg <= '0;
        end
        else
        begin
            if (en_f[0]) vf_reg[0] <= s_tvalid;
            if (en_f[1]) vf_reg[1] <= vf_reg[0];
            if (en_f[2]) vf_reg[2] <= vf_reg[1];
            if (en_b[0]) vb_reg[0] <= exp_out_valid;
            if (en_b[1]) vb_reg[1] <= vb_reg[0];
            if (en_b[2]) vb_reg[2] <= vb_reg[1];
        end
    end

    // Front: start gate, |u| in Q24 with far-field flush, t1 in Q32.
    always_comb
    begin
        f1_zero_next = $signed(s_tdata) < $signed(start_time_reg);
        f1_d = {s_tdata[31], s_tdata} - {center_time_reg[31], center_time_reg};
        f1_absd_next = f1_d[32] ? 32'(-f1_d) : f1_d[31:0];
        f2_p = 64'(f1_absd_reg) * 64'(scale_reg);
        f2_zero_next = f1_zero_reg || (f2_p[63:46] >= 18'd6);
        f2_u24_next = f2_p[48:22];
        f3_sq = 55'(f2_u24_reg) * 55'(f2_u24_reg) + 55'd32768;
        f3_t1_next = f3_sq[53:16];
    end

    always_ff @(posedge clk)
    begin
        if (en_f[0])
        begin
            f1_zero_reg <= f1_zero_next;
            f1_absd_reg <= f1_absd_next;
        end
        if (en_f[1])
        begin
            f2_zero_reg <= f2_zero_next;
            f2_u24_reg <= f2_u24_next;
        end
        if (en_f[2])
        begin
            f3_zero_reg <= f2_zero_reg;
            f3_t1_reg <= f3_t1_next;
        end
    end

    // The polynomial factor |1 - 2*t1| rides along with the exp pipeline.
    always_comb
    begin
        two_t1 = {f3_t1_reg, 1'b0};
        tag_in.zero = f3_zero_reg;
        tag_in.neg = two_t1 > TWO_POW32;
        pm = tag_in.neg ? (two_t1 - TWO_POW32) : (TWO_POW32 - two_t1);
        tag_in.pm_hi = pm[38:8];
    end

    rwg_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vf_reg[2]),
        .in_ready  (exp_in_ready),
        .t1        (f3_t1_reg),
        .tag_in    (tag_in),
        .out_valid (exp_out_valid),
        .out_ready (en_b[0]),
        .e_out     (exp_e),
        .tag_out   (tag_out)
    );

    // Back: wavelet value, gain with rounding, sign, saturation and the zero gate.
    always_comb
    begin
        b1_wp = 62'(tag_out.pm_hi) * 62'(exp_e);
        b1_w_next = b1_wp[54:24];
        b2_mp = 64'(b1_w_reg) * 64'(gain_reg) + (64'd1 << 29);
        b2_mag_next = b2_mp[63:30];
        b3_neg = b2_neg_reg ^ negate_reg;
        out_amp_next = 32'd0;
        out_sat_next = 1'b0;
        if (!b2_zero_reg)
        begin
            if (!b3_neg)
            begin
                if (b2_mag_reg > 34'h0_7FFF_FFFF)
                begin
                    out_amp_next = 32'h7FFF_FFFF;
                    out_sat_next = 1'b1;
                end
                else
                begin
                    out_amp_next = b2_mag_reg[31:0];
                end
            end
            else
            begin
                if (b2_mag_reg > 34'h0_8000_0000)
                begin
                    out_amp_next = 32'h8000_0000;
                    out_sat_next = 1'b1;
                end
                else
                begin
                    out_amp_next = 32'd0 - b2_mag_reg[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b[0])
        begin
            b1_w_reg <= b1_w_next;
            b1_zero_reg <= tag_out.zero;
            b1_neg_reg <= tag_out.neg;
        end
        if (en_b[1])
        begin
            b2_mag_reg <= b2_mag_next;
            b2_zero_reg <= b1_zero_reg;
            b2_neg_reg <= b1_neg_reg;
        end
        if (en_b[2])
        begin
            out_amp_reg <= out_amp_next;
            out_sat_reg <= out_sat_next;
        end
    end

    a_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && ($signed(s_tdata) < $signed(start_time_reg))
        |=> f1_zero_reg)
        else $error("sample before start time was not marked for zero output");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg[1] && en_b[2] && b2_zero_reg |=> (m_tdata == 32'd0) && !m_tuser)
        else $error("gated or flushed sample gave a nonzero result");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 32'h7FFF_FFFF) || (m_tdata == 32'h8000_0000))
        else $error("saturation flag set on an unclipped amplitude");

    a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
        !vf_reg[0] |-> s_tready)
        else $error("input not ready although the first stage is empty");

endmodule
